@@ src/brct_pkg.sv @@
// Package for the block range conflict tracker.
// Holds sizes, the transaction payload structs and the compare result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brct_pkg;

  localparam int BUCKETS          = 16;
  localparam int SLOTS_PER_BUCKET = 32;
  localparam int REQUESTS         = 64;
  localparam int BUCKET_W         = $clog2(BUCKETS);
  localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
  localparam int ALL_SLOTS        = BUCKETS * SLOTS_PER_BUCKET;
  localparam int GSLOT_W          = BUCKET_W + SLOT_W;
  localparam int TAG_W            = 6;
  localparam int LINK_W           = TAG_W + 1;

  localparam logic       FUNC_INSERT  = 1'b0;
  localparam logic       FUNC_RELEASE = 1'b1;
  localparam logic       STATUS_DONE  = 1'b0;
  localparam logic       STATUS_FULL  = 1'b1;
  // link with the top bit set means no request
  localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {TAG_W{1'b0}}};

  typedef struct packed {
    logic        func;
    logic [5:0]  tag;
    logic [7:0]  request_opcode;
    logic [63:0] fid_high;
    logic [63:0] fid_low;
    logic [47:0] block_start;
    logic [31:0] block_count;
    logic [12:0] entry_index;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        runnable;
    logic [12:0] assigned_index;
    logic        woken_valid;
    logic [5:0]  woken_tag;
    logic [7:0]  woken_opcode;
  } out_t;

  typedef struct packed {
    logic fid_eq;
    logic overlap;
  } cmp_t;

endpackage
`default_nettype wire

@@ src/brct_cmp.sv @@
// Shared compare unit: object id equality and block range overlap.
// Depends on brct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brct_cmp (
  input  wire logic [127:0]        fid_a,
  input  wire logic [127:0]        fid_b,
  input  wire logic [47:0]         start_a,
  input  wire logic [48:0]         end_a,
  input  wire logic [47:0]         start_b,
  input  wire logic [48:0]         end_b,
  output brct_pkg::cmp_t           res
);
  import brct_pkg::*;

  always_comb begin
    res.fid_eq  = (fid_a == fid_b);
    // ranges are half open, ends never wrap
    res.overlap = !((end_a <= {1'b0, start_b}) || ({1'b0, start_a} >= end_b));
  end

endmodule
`default_nettype wire

@@ src/block_range_conflict_tracker_unit.sv @@
// Block range conflict tracker: top level with sequencer and state memories; needs brct_pkg, brct_cmp.
// Insert scans the bucket's slots (up to 32), then allocates a new slot or walks the
// requests queued on the matching slot; a repeat insert returns the stored result; release
// may wake the next request or unlink further down; an out of range release goes straight to the result.
// One transaction at a time, in_ready only when idle; a stalled result holds the
// sequencer in its last state. Reset clears the slot bitmap, queued bits and serialize_all.
`timescale 1ns / 1ps
`default_nettype none
module block_range_conflict_tracker_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire brct_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output brct_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata
);
  import brct_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DUP_RD   = 5'd1;
  localparam logic [4:0] S_DUP_EV   = 5'd2;
  localparam logic [4:0] S_SCAN_RD  = 5'd3;
  localparam logic [4:0] S_SCAN_CMP = 5'd4;
  localparam logic [4:0] S_ALLOC    = 5'd5;
  localparam logic [4:0] S_HEAD_RD  = 5'd6;
  localparam logic [4:0] S_HEAD_EV  = 5'd7;
  localparam logic [4:0] S_WALK_RD  = 5'd8;
  localparam logic [4:0] S_WALK_CMP = 5'd9;
  localparam logic [4:0] S_INS_WR   = 5'd10;
  localparam logic [4:0] S_INS_LINK = 5'd11;
  localparam logic [4:0] S_REL_RD   = 5'd12;
  localparam logic [4:0] S_REL_EV   = 5'd13;
  localparam logic [4:0] S_WAKE_RD  = 5'd14;
  localparam logic [4:0] S_WAKE_EV  = 5'd15;
  localparam logic [4:0] S_UNL_RD   = 5'd16;
  localparam logic [4:0] S_UNL_EV   = 5'd17;
  localparam logic [4:0] S_REL_FREE = 5'd18;
  localparam logic [4:0] S_DONE     = 5'd19;

  localparam logic [TAG_W:0] STEP_LAST = (TAG_W+1)'(REQUESTS - 1);

  logic [4:0]          state;
  logic                serialize_all;
  logic [ALL_SLOTS-1:0] in_use;
  logic [REQUESTS-1:0] queued;

  logic [TAG_W-1:0]    tag_r;
  logic [7:0]          op_r;
  logic [127:0]        fid_r;
  logic [47:0]         start_r;
  logic [48:0]         end_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [SLOT_W-1:0]   s_cnt;
  logic                free_found;
  logic [SLOT_W-1:0]   free_s;
  logic [GSLOT_W-1:0]  g_r;
  logic [LINK_W-1:0]   cur, head_r, tail_r, nxt_r;
  logic [TAG_W:0]      steps;
  logic                run_r;
  out_t                res;

  // memories
  logic [127:0]        fid_mem  [ALL_SLOTS];
  logic [LINK_W-1:0]   head_mem [ALL_SLOTS];
  logic [LINK_W-1:0]   tail_mem [ALL_SLOTS];
  logic [LINK_W-1:0]   next_mem [REQUESTS];
  logic [47:0]         start_mem[REQUESTS];
  logic [48:0]         end_mem  [REQUESTS];
  logic [7:0]          op_mem   [REQUESTS];
  logic                run_mem  [REQUESTS];
  logic [GSLOT_W-1:0]  slot_mem [REQUESTS];

  logic [127:0]        fid_rd;
  logic [LINK_W-1:0]   head_rd, tail_rd, next_rd;
  logic [47:0]         start_rd;
  logic [48:0]         end_rd;
  logic [7:0]          op_rd;
  logic                run_rd;
  logic [GSLOT_W-1:0]  slot_rd;

  logic [GSLOT_W-1:0]  fid_raddr;
  logic [TAG_W-1:0]    req_raddr;

  logic                fid_we, head_we, tail_we, next_we, req_we, run_we;
  logic [LINK_W-1:0]   head_wd, tail_wd, next_wd;
  logic [TAG_W-1:0]    next_wa, run_wa;
  logic                run_wd;

  cmp_t                cmp;
  logic                in_acc;
  logic [GSLOT_W-1:0]  scan_g;
  logic                scan_used;
  logic [LINK_W-1:0]   tag_link;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign scan_g    = {bucket_r, s_cnt};
  assign scan_used = in_use[scan_g];
  assign tag_link  = {1'b0, tag_r};
  assign fid_raddr = scan_g;

  brct_cmp u_cmp (
    .fid_a  (fid_r),
    .fid_b  (fid_rd),
    .start_a(start_r),
    .end_a  (end_r),
    .start_b(start_rd),
    .end_b  (end_rd),
    .res    (cmp)
  );

  always_comb begin
    unique case (state)
      S_WALK_RD: req_raddr = cur[TAG_W-1:0];
      S_WAKE_RD: req_raddr = nxt_r[TAG_W-1:0];
      S_UNL_RD:  req_raddr = cur[TAG_W-1:0];
      default:   req_raddr = tag_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fid_we) begin
      fid_mem[g_r] <= fid_r;
    end
    if (head_we) begin
      head_mem[g_r] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[g_r] <= tail_wd;
    end
    fid_rd  <= fid_mem[fid_raddr];
    head_rd <= head_mem[g_r];
    tail_rd <= tail_mem[g_r];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (run_we) begin
      run_mem[run_wa] <= run_wd;
    end
    if (req_we) begin
      start_mem[tag_r] <= start_r;
      end_mem[tag_r]   <= end_r;
      op_mem[tag_r]    <= op_r;
      slot_mem[tag_r]  <= g_r;
    end
    next_rd  <= next_mem[req_raddr];
    start_rd <= start_mem[req_raddr];
    end_rd   <= end_mem[req_raddr];
    op_rd    <= op_mem[req_raddr];
    run_rd   <= run_mem[req_raddr];
    slot_rd  <= slot_mem[req_raddr];
  end

  // memory write strobes
  always_comb begin
    fid_we  = 1'b0;
    head_we = 1'b0;
    tail_we = 1'b0;
    next_we = 1'b0;
    req_we  = 1'b0;
    run_we  = 1'b0;
    head_wd = LINK_NIL;
    tail_wd = LINK_NIL;
    next_wd = LINK_NIL;
    next_wa = tag_r;
    run_wa  = tag_r;
    run_wd  = run_r;
    unique case (state)
      S_ALLOC: begin
        fid_we  = 1'b1;
        head_we = 1'b1;
        tail_we = 1'b1;
      end
      S_INS_WR: begin
        req_we  = 1'b1;
        run_we  = 1'b1;
        next_we = 1'b1;
        tail_we = 1'b1;
        tail_wd = tag_link;
        head_we = head_r[TAG_W];
        head_wd = tag_link;
      end
      S_INS_LINK: begin
        next_we = 1'b1;
        next_wa = tail_r[TAG_W-1:0];
        next_wd = tag_link;
      end
      S_REL_EV: begin
        if (queued[tag_r] && slot_rd == g_r && head_rd == tag_link) begin
          head_we = 1'b1;
          head_wd = next_rd;
          tail_we = (tail_rd == tag_link);
        end
      end
      S_WAKE_EV: begin
        run_we = !run_rd;
        run_wa = nxt_r[TAG_W-1:0];
        run_wd = 1'b1;
      end
      S_UNL_EV: begin
        if (next_rd == tag_link) begin
          next_we = 1'b1;
          next_wa = cur[TAG_W-1:0];
          next_wd = nxt_r;
          tail_we = (tail_r == tag_link);
          tail_wd = cur;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serialize_all <= 1'b0;
    end else if (cfg_we) begin
      serialize_all <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      queued    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            tag_r      <= in_data.tag;
            op_r       <= in_data.request_opcode;
            fid_r      <= {in_data.fid_high, in_data.fid_low};
            start_r    <= in_data.block_start;
            end_r      <= {1'b0, in_data.block_start} + {17'b0, in_data.block_count};
            bucket_r   <= BUCKET_W'(in_data.fid_low[7:0] % BUCKETS);
            s_cnt      <= '0;
            free_found <= 1'b0;
            res        <= '0;
            g_r        <= {in_data.entry_index[BUCKET_W-1:0],
                           in_data.entry_index[8 +: SLOT_W]};
            if (in_data.func == FUNC_INSERT) begin
              state <= queued[in_data.tag] ? S_DUP_RD : S_SCAN_RD;
            end else if (in_data.entry_index[7:BUCKET_W] != '0) begin
              state <= S_DONE;
            end else begin
              state <= S_REL_RD;
            end
          end
        end
        S_DUP_RD: state <= S_DUP_EV;
        S_DUP_EV: begin
          res.runnable       <= run_rd;
          res.assigned_index <= {slot_rd[SLOT_W-1:0], (8-BUCKET_W)'(0),
                                 slot_rd[GSLOT_W-1:SLOT_W]};
          state              <= S_DONE;
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (scan_used && cmp.fid_eq) begin
            g_r   <= scan_g;
            state <= S_HEAD_RD;
          end else begin
            if (!scan_used && !free_found) begin
              free_found <= 1'b1;
              free_s     <= s_cnt;
            end
            if (s_cnt == SLOT_W'(SLOTS_PER_BUCKET - 1)) begin
              if (free_found) begin
                g_r   <= {bucket_r, free_s};
                state <= S_ALLOC;
              end else if (!scan_used) begin
                g_r   <= scan_g;
                state <= S_ALLOC;
              end else begin
                res.status <= STATUS_FULL;
                state      <= S_DONE;
              end
            end else begin
              s_cnt <= s_cnt + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_ALLOC: begin
          in_use[g_r] <= 1'b1;
          head_r      <= LINK_NIL;
          tail_r      <= LINK_NIL;
          run_r       <= 1'b1;
          state       <= S_INS_WR;
        end
        S_HEAD_RD: state <= S_HEAD_EV;
        S_HEAD_EV: begin
          head_r <= head_rd;
          tail_r <= tail_rd;
          cur    <= head_rd;
          steps  <= '0;
          run_r  <= !(!head_rd[TAG_W] && serialize_all);
          if (!head_rd[TAG_W] && !serialize_all) begin
            state <= S_WALK_RD;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_WALK_RD: state <= S_WALK_CMP;
        S_WALK_CMP: begin
          if (cmp.overlap) begin
            run_r <= 1'b0;
            state <= S_INS_WR;
          end else begin
            cur   <= next_rd;
            steps <= steps + 1'b1;
            state <= (next_rd[TAG_W] || steps == STEP_LAST) ? S_INS_WR : S_WALK_RD;
          end
        end
        S_INS_WR: begin
          queued[tag_r]      <= 1'b1;
          res.runnable       <= run_r;
          res.assigned_index <= {g_r[SLOT_W-1:0], (8-BUCKET_W)'(0),
                                 g_r[GSLOT_W-1:SLOT_W]};
          state <= (!head_r[TAG_W] && !tail_r[TAG_W]) ? S_INS_LINK : S_DONE;
        end
        S_INS_LINK: state <= S_DONE;
        S_REL_RD: state <= S_REL_EV;
        S_REL_EV: begin
          nxt_r  <= next_rd;
          tail_r <= tail_rd;
          cur    <= head_rd;
          steps  <= '0;
          if (!(queued[tag_r] && slot_rd == g_r)) begin
            head_r <= head_rd;
            state  <= S_REL_FREE;
          end else begin
            queued[tag_r] <= 1'b0;
            if (head_rd == tag_link) begin
              head_r <= next_rd;
              state  <= next_rd[TAG_W] ? S_REL_FREE : S_WAKE_RD;
            end else begin
              head_r <= head_rd;
              state  <= head_rd[TAG_W] ? S_REL_FREE : S_UNL_RD;
            end
          end
        end
        S_WAKE_RD: state <= S_WAKE_EV;
        S_WAKE_EV: begin
          if (!run_rd) begin
            res.woken_valid  <= 1'b1;
            res.woken_tag    <= nxt_r[TAG_W-1:0];
            res.woken_opcode <= op_rd;
          end
          state <= S_REL_FREE;
        end
        S_UNL_RD: state <= S_UNL_EV;
        S_UNL_EV: begin
          if (next_rd == tag_link) begin
            state <= S_REL_FREE;
          end else begin
            cur   <= next_rd;
            steps <= steps + 1'b1;
            state <= (next_rd[TAG_W] || steps == STEP_LAST) ? S_REL_FREE : S_UNL_RD;
          end
        end
        S_REL_FREE: begin
          if (head_r[TAG_W]) begin
            in_use[g_r] <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("sequencer idle right after accepting a transaction");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid && state == S_IDLE)
    else $error("result not loaded on completion");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_FULL) |->
      (!out_data.runnable && !out_data.woken_valid && out_data.assigned_index == '0))
    else $error("full status with other fields set");

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> !in_use[g_r])
    else $error("allocating an occupied slot");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for block_range_conflict_tracker_unit: directed and random transactions
// checked against a behavioural tracker model kept in this file.
// Depends on brct_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb;
  import brct_pkg::*;

  localparam int NONE  = -1;
  localparam int LIMIT = 2000000;
  localparam int DRAIN = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  block_range_conflict_tracker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // tracker model state
  bit              serialise;
  bit              slot_busy [ALL_SLOTS];
  bit              slot_seen [ALL_SLOTS];
  logic [127:0]    slot_id [ALL_SLOTS];
  int              q_head [ALL_SLOTS];
  int              q_tail [ALL_SLOTS];
  int              link [REQUESTS];
  longint unsigned blk_first [REQUESTS];
  longint unsigned blk_len [REQUESTS];
  logic [7:0]      held_op [REQUESTS];
  bit              running [REQUESTS];
  bit              queued [REQUESTS];
  int              home_slot [REQUESTS];
  int              seen_slots [$];

  out_t   pending_results [$];
  int     errors = 0;
  longint cycles = 0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  int     rx_hold = 0;
  logic [127:0] id_pool [10];

  function automatic logic [12:0] index_of_slot(int g);
    logic [4:0] s;
    logic [7:0] b;
    s = 5'(g % SLOTS_PER_BUCKET);
    b = 8'(g / SLOTS_PER_BUCKET);
    return {s, b};
  endfunction

  task automatic track(input in_t x, output out_t r);
    int bucket, base, g, cur, steps, n, prev;
    bit run;
    longint unsigned first, last;
    r = '0;
    if (x.func == FUNC_INSERT) begin
      if (queued[x.tag]) begin
        r.runnable = running[x.tag];
        r.assigned_index = index_of_slot(home_slot[x.tag]);
        return;
      end
      bucket = x.fid_low[7:0] % BUCKETS;
      base = bucket * SLOTS_PER_BUCKET;
      g = NONE;
      for (int s = 0; s < SLOTS_PER_BUCKET && g == NONE; s++)
        if (slot_busy[base+s] && slot_id[base+s] == {x.fid_high, x.fid_low}) g = base + s;
      for (int s = 0; s < SLOTS_PER_BUCKET && g == NONE; s++)
        if (!slot_busy[base+s]) begin
          g = base + s;
          slot_busy[g] = 1'b1;
          if (!slot_seen[g]) seen_slots.push_back(g);
          slot_seen[g] = 1'b1;
          slot_id[g] = {x.fid_high, x.fid_low};
          q_head[g] = NONE;
          q_tail[g] = NONE;
        end
      if (g == NONE) begin
        r.status = STATUS_FULL;
        return;
      end
      first = x.block_start;
      last = first + x.block_count;
      cur = q_head[g];
      run = !(cur != NONE && serialise);
      for (steps = 0; run && cur != NONE && steps < REQUESTS; steps++) begin
        if (!(last <= blk_first[cur] || first >= blk_first[cur] + blk_len[cur])) run = 1'b0;
        cur = link[cur];
      end
      blk_first[x.tag] = first;
      blk_len[x.tag] = x.block_count;
      held_op[x.tag] = x.request_opcode;
      running[x.tag] = run;
      link[x.tag] = NONE;
      queued[x.tag] = 1'b1;
      home_slot[x.tag] = g;
      if (q_head[g] == NONE) q_head[g] = x.tag;
      else if (q_tail[g] != NONE) link[q_tail[g]] = x.tag;
      q_tail[g] = x.tag;
      r.runnable = run;
      r.assigned_index = index_of_slot(g);
    end else begin
      if (x.entry_index[7:0] >= BUCKETS) return;
      g = x.entry_index[7:0] * SLOTS_PER_BUCKET + x.entry_index[12:8];
      if (queued[x.tag] && home_slot[x.tag] == g) begin
        n = link[x.tag];
        if (q_head[g] == x.tag) begin
          q_head[g] = n;
          if (q_tail[g] == x.tag) q_tail[g] = NONE;
          if (n != NONE && !running[n]) begin
            running[n] = 1'b1;
            r.woken_valid = 1'b1;
            r.woken_tag = 6'(n);
            r.woken_opcode = held_op[n];
          end
        end else begin
          prev = q_head[g];
          for (steps = 0; prev != NONE && steps < REQUESTS; steps++) begin
            if (link[prev] == x.tag) begin
              link[prev] = n;
              if (q_tail[g] == x.tag) q_tail[g] = prev;
              break;
            end
            prev = link[prev];
          end
        end
        queued[x.tag] = 1'b0;
        link[x.tag] = NONE;
      end
      if (q_head[g] == NONE) slot_busy[g] = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (tx_steady || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // one transaction; valid stays high when the next follows with no gap
  task automatic send(input in_t x);
    out_t r;
    int gap;
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    track(x, r);
    pending_results.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every result is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_serialise(input bit v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    serialise = v;
  endtask

  function automatic in_t insert_item(int tag, logic [127:0] id, longint unsigned first,
                                      longint unsigned len, logic [7:0] op);
    in_t x;
    x = '0;
    x.func = FUNC_INSERT;
    x.tag = 6'(tag);
    x.request_opcode = op;
    {x.fid_high, x.fid_low} = id;
    x.block_start = 48'(first);
    x.block_count = 32'(len);
    x.entry_index = 13'($urandom);
    return x;
  endfunction

  function automatic in_t release_item(int tag, logic [12:0] idx);
    in_t x;
    x = '0;
    x.func = FUNC_RELEASE;
    x.tag = 6'(tag);
    x.entry_index = idx;
    x.request_opcode = 8'($urandom);
    x.fid_high = {$urandom, $urandom};
    x.fid_low = {$urandom, $urandom};
    x.block_start = 48'({$urandom, $urandom});
    x.block_count = $urandom;
    return x;
  endfunction

  function automatic in_t random_item();
    int p, tag, nq;
    logic [127:0] id;
    longint unsigned first, len;
    logic [12:0] idx;
    nq = 0;
    foreach (queued[i]) nq += queued[i];
    p = $urandom_range(0, 99);
    if (p < 15 + nq) begin
      tag = $urandom_range(0, REQUESTS - 1);
      p = $urandom_range(0, 99);
      if (p < 80) begin
        for (int k = 0; k < 8 && !queued[tag]; k++) tag = $urandom_range(0, REQUESTS - 1);
        idx = queued[tag] ? index_of_slot(home_slot[tag])
                          : index_of_slot(seen_slots[$urandom_range(0, seen_slots.size()-1)]);
      end else if (p < 92 && seen_slots.size() != 0) begin
        idx = index_of_slot(seen_slots[$urandom_range(0, seen_slots.size() - 1)]);
      end else begin
        idx = {5'($urandom), 8'($urandom_range(BUCKETS, 255))};
      end
      if (seen_slots.size() == 0 && p < 92) idx = {5'($urandom), 8'hFF};
      return release_item(tag, idx);
    end
    tag = $urandom_range(0, REQUESTS - 1);
    if ($urandom_range(0, 9) != 0)
      for (int k = 0; k < 8 && queued[tag]; k++) tag = $urandom_range(0, REQUESTS - 1);
    id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom, $urandom, $urandom}
                                     : id_pool[$urandom_range(0, 9)];
    if ($urandom_range(0, 4) == 0) begin
      first = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
      len = $urandom;
    end else begin
      first = $urandom_range(0, 63);
      len = $urandom_range(0, 16);
    end
    return insert_item(tag, id, first, len, 8'($urandom));
  endfunction

  task automatic test_basic_queue();
    logic [127:0] a, b;
    a = id_pool[0];
    b = {id_pool[1][127:4], a[3:0]};
    send(insert_item(0, a, 100, 10, 8'h11));
    send(insert_item(1, a, 105, 10, 8'h22));
    send(insert_item(2, a, 200, 5, 8'h33));
    send(insert_item(1, a, 0, 1, 8'h44));
    send(insert_item(3, b, 100, 10, 8'h55));
    send(release_item(2, index_of_slot(home_slot[2])));
    send(release_item(0, index_of_slot(home_slot[0])));
    send(release_item(9, index_of_slot(home_slot[1])));
    send(release_item(1, index_of_slot(home_slot[1])));
    send(release_item(3, index_of_slot(home_slot[3])));
    send(release_item(3, 13'h1FFF));
  endtask

  task automatic test_field_extremes();
    logic [127:0] ones;
    ones = '1;
    send(insert_item(63, ones, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    send(insert_item(62, ones, 48'hFFFF_FFFF_FFFE, 32'h0, 8'h00));
    send(insert_item(61, '0, 0, 0, 8'h00));
    send(insert_item(60, '0, 0, 32'hFFFF_FFFF, 8'hA5));
    send(release_item(63, index_of_slot(home_slot[63])));
    send(release_item(62, index_of_slot(home_slot[62])));
    send(release_item(61, index_of_slot(home_slot[61])));
    send(release_item(60, index_of_slot(home_slot[60])));
  endtask

  task automatic test_serialise_all();
    set_serialise(1'b1);
    send(insert_item(5, id_pool[2], 0, 4, 8'h5A));
    send(insert_item(6, id_pool[2], 1000, 4, 8'h6B));
    send(release_item(5, index_of_slot(home_slot[5])));
    send(release_item(6, index_of_slot(home_slot[6])));
    set_serialise(1'b0);
  endtask

  // fill every slot of one bucket, then one more id must be refused
  task automatic test_full_bucket();
    logic [127:0] id;
    for (int t = 0; t <= SLOTS_PER_BUCKET; t++) begin
      id = {$urandom, $urandom, $urandom, $urandom};
      id[7:0] = 8'h09 + 8'(16 * (t % 16));
      id[15:8] = 8'(t);
      send(insert_item(10 + t, id, t, 1, 8'(t)));
    end
    for (int t = 0; t < SLOTS_PER_BUCKET; t++)
      send(release_item(10 + t, index_of_slot(home_slot[10 + t])));
  endtask

  task automatic test_random(input int count, input bit ser);
    set_serialise(ser);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) settle();
      tx_steady = (i % 150) < 20;
      rx_steady = (i % 170) < 25;
      send(random_item());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_steady || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (out_valid && out_ready && !rst) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.runnable !== want.runnable ||
            out_data.assigned_index !== want.assigned_index ||
            out_data.woken_valid !== want.woken_valid ||
            out_data.woken_tag !== want.woken_tag ||
            out_data.woken_opcode !== want.woken_opcode) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %b %b %h %b %0d %h, got %b %b %h %b %0d %h",
                     want.status, want.runnable, want.assigned_index, want.woken_valid,
                     want.woken_tag, want.woken_opcode, out_data.status, out_data.runnable,
                     out_data.assigned_index, out_data.woken_valid, out_data.woken_tag,
                     out_data.woken_opcode);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    serialise = 1'b0;
    foreach (queued[i]) begin
      queued[i] = 1'b0;
      link[i] = NONE;
    end
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    // ids crowd three buckets so queues and slot reuse happen often
    foreach (id_pool[i]) begin
      id_pool[i] = {$urandom, $urandom, $urandom, $urandom};
      id_pool[i][3:0] = (i < 5) ? 4'h3 : (i < 8) ? 4'h7 : 4'hC;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_queue();
    test_field_extremes();
    test_serialise_all();
    test_full_bucket();
    test_random(450, 1'b0);
    test_random(400, 1'b1);
    test_random(450, 1'b0);
    test_random(400, 1'b1);
    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ block_range_conflict_tracker_unit.f @@
src/brct_pkg.sv
src/brct_cmp.sv
src/block_range_conflict_tracker_unit.sv
sim/tb.sv
